// ===== hdl/sps_pkg.sv =====
// Shared constants, register indexes and neighbour offset tables for the
// small particle sieve. No dependencies.
package sps_pkg;

  localparam int unsigned DefMaxWidth    = 256;
  localparam int unsigned DefMaxHeight   = 256;
  localparam int unsigned DefMaxParticle = 16;
  localparam int unsigned CodeW          = 8;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_WIDTH  = 3'd0,
    REG_HEIGHT = 3'd1,
    REG_LIMIT  = 3'd2,
    REG_LAND   = 3'd3,
    REG_CLOUD  = 3'd4,
    REG_SNOW   = 3'd5
  } cfg_reg_e;

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  // offsets are coded as 0 = -1, 1 = 0, 2 = +1
  // 8-neighbourhood scan: k = 0..8, centre at k = 4
  function automatic logic [1:0] nb8_dx(input logic [3:0] k);
    logic [1:0] r;
    case (k)
      4'd0, 4'd3, 4'd6: r = 2'd0;
      4'd1, 4'd4, 4'd7: r = 2'd1;
      default:          r = 2'd2;
    endcase
    return r;
  endfunction

  function automatic logic [1:0] nb8_dy(input logic [3:0] k);
    logic [1:0] r;
    case (k)
      4'd0, 4'd1, 4'd2: r = 2'd0;
      4'd3, 4'd4, 4'd5: r = 2'd1;
      default:          r = 2'd2;
    endcase
    return r;
  endfunction

  // 4-neighbourhood: up, left, right, down
  function automatic logic [1:0] nb4_dx(input logic [1:0] k);
    logic [1:0] r;
    case (k)
      2'd1:    r = 2'd0;
      2'd2:    r = 2'd2;
      default: r = 2'd1;
    endcase
    return r;
  endfunction

  function automatic logic [1:0] nb4_dy(input logic [1:0] k);
    logic [1:0] r;
    case (k)
      2'd0:    r = 2'd0;
      2'd3:    r = 2'd2;
      default: r = 2'd1;
    endcase
    return r;
  endfunction

endpackage

// ===== hdl/sps_ram.sv =====
// Generic single-port synchronous RAM with registered read data.
// No dependencies.
module sps_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/small_particle_sieve_top.sv =====
// Small particle sieve on a stored class-mask image. A load (cmd 0) writes one
// pixel, gives no result and never stalls the input. A query (cmd 1) flood-fills
// the pixel's 4-connected particle from the image RAM, reading one neighbour at a
// time, and gives one result; the input stays stalled until that result enters
// the output register, and a stalled earlier result keeps it stalled. A query
// outside the image, or on a code that is not a class, skips the fill. The fill
// ends early once the particle is found too large. When the limit is below 9,
// an 8-neighbour pre-check of equal pixels runs before the fill. The single
// image RAM port sets the pace.
// Depends on sps_pkg and sps_ram.
module small_particle_sieve_top
  import sps_pkg::*;
#(
  parameter int unsigned MAX_WIDTH    = DefMaxWidth,
  parameter int unsigned MAX_HEIGHT   = DefMaxHeight,
  parameter int unsigned MAX_PARTICLE = DefMaxParticle
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  // input items
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic             cmd_i,
  input  logic [7:0]       pixel_x_i,
  input  logic [7:0]       pixel_y_i,
  input  logic [CodeW-1:0] pixel_value_i,
  // result items
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [CodeW-1:0] sieved_value_o,
  output logic             was_replaced_o,
  // configuration writes
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [2:0]       cfg_index_i,
  input  logic [8:0]       cfg_data_i
);

  localparam int unsigned XW    = $clog2(MAX_WIDTH);
  localparam int unsigned YW    = $clog2(MAX_HEIGHT);
  localparam int unsigned AW    = XW + YW;
  localparam int unsigned Depth = 1 << AW;
  localparam int unsigned CW0   = (XW > YW) ? XW : YW;
  localparam int unsigned CW    = ((CW0 > 8) ? CW0 : 8) + 1;
  localparam int unsigned PW    = $clog2(MAX_PARTICLE + 1);
  localparam int unsigned IW    = (MAX_PARTICLE > 1) ? $clog2(MAX_PARTICLE) : 1;
  localparam int unsigned LW    = (PW > 5) ? PW : 5;
  localparam int unsigned RCW   = $clog2(4 * MAX_PARTICLE + 1);

  typedef enum logic [2:0] {
    S_IDLE, S_CENTER, S_PRE_ADDR, S_PRE_DATA, S_POP, S_NB_ADDR, S_NB_DATA, S_EMIT
  } state_e;

  typedef enum logic [1:0] { K_LAND, K_CLOUD, K_SNOW } kind_e;

  // configuration registers
  logic [8:0]       width_q, height_q;
  logic [4:0]       limit_q;
  logic [CodeW-1:0] land_q, cloud_q, snow_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= 9'd256;
      height_q <= 9'd256;
      limit_q  <= 5'd5;
      land_q   <= 8'd0;
      cloud_q  <= 8'd1;
      snow_q   <= 8'd2;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_WIDTH:  width_q  <= cfg_data_i;
        REG_HEIGHT: height_q <= cfg_data_i;
        REG_LIMIT:  limit_q  <= cfg_data_i[4:0];
        REG_LAND:   land_q   <= cfg_data_i[7:0];
        REG_CLOUD:  cloud_q  <= cfg_data_i[7:0];
        REG_SNOW:   snow_q   <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // effective size and limit
  logic [CW-1:0] w_eff, h_eff;
  logic [LW-1:0] lim, allowed;

  always_comb begin
    if (width_q == 9'd0) w_eff = CW'(1);
    else if (CW'(width_q) > CW'(MAX_WIDTH)) w_eff = CW'(MAX_WIDTH);
    else w_eff = CW'(width_q);
    if (height_q == 9'd0) h_eff = CW'(1);
    else if (CW'(height_q) > CW'(MAX_HEIGHT)) h_eff = CW'(MAX_HEIGHT);
    else h_eff = CW'(height_q);
    if (LW'(limit_q) > LW'(MAX_PARTICLE)) lim = LW'(MAX_PARTICLE);
    else lim = LW'(limit_q);
    allowed = (lim == '0) ? LW'(1) : lim;
  end

  // control and working registers
  state_e           state_q;
  kind_e            kind_q;
  logic [CW-1:0]    x_q, y_q;
  logic [CodeW-1:0] val_q;
  logic [3:0]       k_q, same_q;
  logic [PW-1:0]    cnt_q, sp_q;
  logic [AW-1:0]    cur_q, nb_addr_q;
  logic [RCW-1:0]   cnt_a_q, cnt_b_q;
  logic             out_valid_q, out_rep_q;
  logic [CodeW-1:0] out_val_q;
  logic [AW-1:0]    visited_q [MAX_PARTICLE];
  logic [AW-1:0]    stack_q   [MAX_PARTICLE];

  logic in_acc;
  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;

  // image RAM
  logic             ram_we;
  logic [AW-1:0]    ram_addr;
  logic [CodeW-1:0] ram_rdata;

  sps_ram #(.WIDTH(CodeW), .DEPTH(Depth)) u_image (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (pixel_value_i),
    .rdata_o (ram_rdata)
  );

  // port coordinates
  logic [CW-1:0] px_w, py_w;
  logic          p_in;
  assign px_w = CW'(pixel_x_i);
  assign py_w = CW'(pixel_y_i);
  assign p_in = (px_w < w_eff) && (py_w < h_eff);

  // neighbour address generation
  logic [CW-1:0] cx, cy, pre_nx, pre_ny, nb_nx, nb_ny;
  logic          pre_ok, nb_ok;
  logic [AW-1:0] pre_addr, nb_addr, ctr_addr;

  assign cx       = CW'(cur_q[XW-1:0]);
  assign cy       = CW'(cur_q[AW-1:XW]);
  assign pre_nx   = x_q + CW'(nb8_dx(k_q)) - CW'(1);
  assign pre_ny   = y_q + CW'(nb8_dy(k_q)) - CW'(1);
  assign pre_ok   = (k_q != 4'd4) && (pre_nx < w_eff) && (pre_ny < h_eff);
  assign pre_addr = {pre_ny[YW-1:0], pre_nx[XW-1:0]};
  assign nb_nx    = cx + CW'(nb4_dx(k_q[1:0])) - CW'(1);
  assign nb_ny    = cy + CW'(nb4_dy(k_q[1:0])) - CW'(1);
  assign nb_ok    = (nb_nx < w_eff) && (nb_ny < h_eff);
  assign nb_addr  = {nb_ny[YW-1:0], nb_nx[XW-1:0]};
  assign ctr_addr = {y_q[YW-1:0], x_q[XW-1:0]};

  always_comb begin
    ram_we   = 1'b0;
    ram_addr = {py_w[YW-1:0], px_w[XW-1:0]};
    case (state_q)
      S_IDLE:     ram_we = in_acc && (cmd_i == CMD_LOAD) && p_in;
      S_PRE_ADDR: ram_addr = pre_addr;
      S_NB_ADDR:  ram_addr = nb_addr;
      default: ;
    endcase
  end

  // rival classes of the current kind
  logic [CodeW-1:0] rival_a, rival_b, win_a, win_b;
  always_comb begin
    case (kind_q)
      K_LAND:  begin rival_a = cloud_q; rival_b = snow_q;  win_a = cloud_q; win_b = snow_q; end
      K_CLOUD: begin rival_a = land_q;  rival_b = snow_q;  win_a = land_q;  win_b = snow_q; end
      default: begin rival_a = cloud_q; rival_b = land_q;  win_a = cloud_q; win_b = land_q; end
    endcase
  end

  // visited lookup over the filled entries
  logic hit;
  always_comb begin
    hit = 1'b0;
    for (int i = 0; i < MAX_PARTICLE; i++) begin
      if ((PW'(i) < cnt_q) && (visited_q[i] == nb_addr_q)) hit = 1'b1;
    end
  end

  logic full, match, push, flood_init;
  logic [PW-1:0] sp_m1;
  assign full  = (LW'(cnt_q) >= allowed) || (cnt_q >= PW'(MAX_PARTICLE))
              || (sp_q >= PW'(MAX_PARTICLE));
  assign match = (ram_rdata == val_q);
  assign push  = (state_q == S_NB_DATA) && match && !hit && !full;
  assign sp_m1 = sp_q - PW'(1);

  logic pre_done_small;
  assign pre_done_small = (state_q == S_PRE_ADDR) && (k_q == 4'd9) && !(LW'(same_q) > lim);

  always_comb begin
    flood_init = pre_done_small;
    if (state_q == S_CENTER && !(LW'(9) > lim)) begin
      flood_init = (ram_rdata == land_q) || (ram_rdata == cloud_q) || (ram_rdata == snow_q);
    end
  end

  // visited list and search stack
  always_ff @(posedge clk_i) begin
    if (flood_init) begin
      visited_q[0] <= ctr_addr;
      stack_q[0]   <= ctr_addr;
    end else if (push) begin
      visited_q[cnt_q[IW-1:0]] <= nb_addr_q;
      stack_q[sp_q[IW-1:0]]    <= nb_addr_q;
    end
  end

  // sequencer and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && !out_stall_i && state_q != S_EMIT) out_valid_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            x_q <= px_w;
            y_q <= py_w;
            if (cmd_i == CMD_QUERY) begin
              if (p_in) begin
                state_q <= S_CENTER;
              end else begin
                val_q     <= '0;
                out_rep_q <= 1'b0;
                state_q   <= S_EMIT;
              end
            end
          end
        end
        S_CENTER: begin
          val_q     <= ram_rdata;
          out_rep_q <= 1'b0;
          k_q       <= '0;
          same_q    <= '0;
          if (ram_rdata == land_q) kind_q <= K_LAND;
          else if (ram_rdata == cloud_q) kind_q <= K_CLOUD;
          else kind_q <= K_SNOW;
          if (!((ram_rdata == land_q) || (ram_rdata == cloud_q) || (ram_rdata == snow_q))) begin
            state_q <= S_EMIT;
          end else if (LW'(9) > lim) begin
            state_q <= S_PRE_ADDR;
          end else begin
            state_q <= S_POP;
          end
        end
        S_PRE_ADDR: begin
          if (k_q == 4'd9) begin
            state_q <= (LW'(same_q) > lim) ? S_EMIT : S_POP;
          end else if (pre_ok) begin
            state_q <= S_PRE_DATA;
          end else begin
            k_q <= k_q + 4'd1;
          end
        end
        S_PRE_DATA: begin
          if (match) same_q <= same_q + 4'd1;
          k_q     <= k_q + 4'd1;
          state_q <= S_PRE_ADDR;
        end
        S_POP: begin
          if (sp_q == '0) begin
            val_q     <= (cnt_a_q > cnt_b_q) ? win_a : win_b;
            out_rep_q <= 1'b1;
            state_q   <= S_EMIT;
          end else begin
            cur_q   <= stack_q[sp_m1[IW-1:0]];
            sp_q    <= sp_m1;
            k_q     <= '0;
            state_q <= S_NB_ADDR;
          end
        end
        S_NB_ADDR: begin
          if (k_q == 4'd4) begin
            state_q <= S_POP;
          end else if (nb_ok) begin
            nb_addr_q <= nb_addr;
            state_q   <= S_NB_DATA;
          end else begin
            k_q <= k_q + 4'd1;
          end
        end
        S_NB_DATA: begin
          k_q     <= k_q + 4'd1;
          state_q <= S_NB_ADDR;
          if (!match) begin
            if (ram_rdata == rival_a) cnt_a_q <= cnt_a_q + RCW'(1);
            if (ram_rdata == rival_b) cnt_b_q <= cnt_b_q + RCW'(1);
          end else if (!hit) begin
            if (full) begin
              state_q <= S_EMIT;
            end else begin
              cnt_q <= cnt_q + PW'(1);
              sp_q  <= sp_q + PW'(1);
            end
          end
        end
        S_EMIT: begin
          if (!out_valid_q || !out_stall_i) begin
            out_valid_q <= 1'b1;
            out_val_q   <= val_q;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
      // flood start: centre pixel seeds list and stack
      if (flood_init) begin
        cnt_q   <= PW'(1);
        sp_q    <= PW'(1);
        cnt_a_q <= '0;
        cnt_b_q <= '0;
      end
    end
  end

  // out_rep_q travels with val_q; latched at transfer into the output stage
  logic rep_out_q;
  always_ff @(posedge clk_i) begin
    if (state_q == S_EMIT && (!out_valid_q || !out_stall_i)) rep_out_q <= out_rep_q;
  end

  assign out_valid_o    = out_valid_q;
  assign sieved_value_o = out_val_q;
  assign was_replaced_o = rep_out_q;

endmodule

// ===== hdl/sps_checker.sv =====
// Port-level checks for the small particle sieve, bound to the top level.
// Depends on small_particle_sieve_top.
module sps_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic       cmd_i,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [7:0] sieved_value_o,
  input logic       was_replaced_o
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(sieved_value_o)
      && $stable(was_replaced_o))
    else $error("stalled result changed");

  // a load finishes in the cycle it is taken
  a_load_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && !cmd_i |=> !in_stall_o)
    else $error("load left the block busy");

  // a query keeps the block busy
  a_query_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && cmd_i |=> in_stall_o)
    else $error("query not started");

  // a new result appears as the block goes idle
  a_result_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> !in_stall_o)
    else $error("result shown while busy");

endmodule

bind small_particle_sieve_top sps_checker u_sps_checker (.*);

// ===== tb/sv/sieve_checker.sv =====
// Checker for the small particle sieve: watches the input, result and register
// channels, predicts each query's sieved value and compares. Depends on sps_pkg.
`timescale 1ns / 100ps
module sieve_checker
  import sps_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_stall_i,
  input  logic       cmd_i,
  input  logic [7:0] pixel_x_i,
  input  logic [7:0] pixel_y_i,
  input  logic [7:0] pixel_value_i,
  input  logic       out_valid_i,
  input  logic       out_stall_i,
  input  logic [7:0] sieved_value_i,
  input  logic       was_replaced_i,
  input  logic       cfg_valid_i,
  input  logic       cfg_ready_i,
  input  logic [2:0] cfg_index_i,
  input  logic [8:0] cfg_data_i,
  output int         fail_count_o,
  output int         pending_o
);

  typedef struct packed {
    logic [7:0] value;
    logic       replaced;
  } sieve_res_t;

  logic [7:0] class_img [65536];
  logic [8:0] img_w, img_h;
  logic [4:0] part_lim;
  logic [7:0] land_c, cloud_c, snow_c;
  sieve_res_t expected_sieve[$];

  assign pending_o = expected_sieve.size();

  // sieved value of one pixel from the image as loaded
  function automatic sieve_res_t predict_sieve(input logic [7:0] px, input logic [7:0] py);
    int w, h, lim, allowed, kind, same, sp, vcnt, cnt_a, cnt_b, nx, ny, cx, cy;
    int ox, oy, k, i;
    int dxs[4];
    int dys[4];
    logic [7:0] val, ra, rb, nv;
    logic [15:0] vis[16];
    logic [15:0] stk[16];
    logic [15:0] cur, adr;
    bit is_small, seen;
    sieve_res_t r;
    dxs = '{0, -1, 1, 0};
    dys = '{-1, 0, 0, 1};
    w = (img_w < 1) ? 1 : (img_w > 256) ? 256 : img_w;
    h = (img_h < 1) ? 1 : (img_h > 256) ? 256 : img_h;
    lim = (part_lim < 16) ? part_lim : 16;
    allowed = (lim < 1) ? 1 : lim;
    is_small = 1;
    r = '0;
    if (px >= w || py >= h) return r;
    val = class_img[{py, px}];
    if (val == land_c) begin
      kind = 0; ra = cloud_c; rb = snow_c;
    end else if (val == cloud_c) begin
      kind = 1; ra = land_c; rb = snow_c;
    end else if (val == snow_c) begin
      kind = 2; ra = cloud_c; rb = land_c;
    end else begin
      r.value = val;
      return r;
    end
    // equal-neighbour pre-check
    if (lim < 9) begin
      same = 0;
      for (oy = -1; oy <= 1; oy++)
        for (ox = -1; ox <= 1; ox++) begin
          nx = px + ox; ny = py + oy;
          if ((ox == 0 && oy == 0) || nx < 0 || ny < 0 || nx >= w || ny >= h) continue;
          if (class_img[16'(ny * 256 + nx)] == val) same++;
        end
      if (same > lim) is_small = 0;
    end
    // flood fill with rival border counts
    if (is_small) begin
      cnt_a = 0; cnt_b = 0;
      vcnt = 1;
      vis[0] = {py, px};
      stk[0] = vis[0];
      sp = 1;
      while (sp > 0 && is_small) begin
        sp--;
        cur = stk[sp];
        cx = cur[7:0]; cy = cur[15:8];
        for (k = 0; k < 4 && is_small; k++) begin
          nx = cx + dxs[k]; ny = cy + dys[k];
          if (nx < 0 || ny < 0 || nx >= w || ny >= h) continue;
          adr = 16'(ny * 256 + nx);
          nv = class_img[adr];
          if (nv != val) begin
            if (nv == ra) cnt_a++;
            if (nv == rb) cnt_b++;
          end else begin
            seen = 0;
            for (i = 0; i < vcnt; i++) if (vis[i] == adr) seen = 1;
            if (!seen) begin
              if (vcnt >= allowed || vcnt >= 16 || sp >= 16) is_small = 0;
              else begin
                vis[vcnt] = adr; vcnt++;
                stk[sp] = adr; sp++;
              end
            end
          end
        end
      end
    end
    if (!is_small) begin
      r.value = val;
      return r;
    end
    case (kind)
      0:       r.value = (cnt_a > cnt_b) ? cloud_c : snow_c;
      1:       r.value = (cnt_a > cnt_b) ? land_c : snow_c;
      default: r.value = (cnt_a > cnt_b) ? cloud_c : land_c;
    endcase
    r.replaced = 1'b1;
    return r;
  endfunction

  // track register writes, loads, queries and results
  always @(posedge clk_i or negedge rst_ni) begin
    sieve_res_t exp_r;
    int w, h;
    if (!rst_ni) begin
      img_w <= 9'd256; img_h <= 9'd256; part_lim <= 5'd5;
      land_c <= 8'd0; cloud_c <= 8'd1; snow_c <= 8'd2;
      fail_count_o <= 0;
      expected_sieve.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          REG_WIDTH:  img_w <= cfg_data_i;
          REG_HEIGHT: img_h <= cfg_data_i;
          REG_LIMIT:  part_lim <= cfg_data_i[4:0];
          REG_LAND:   land_c <= cfg_data_i[7:0];
          REG_CLOUD:  cloud_c <= cfg_data_i[7:0];
          REG_SNOW:   snow_c <= cfg_data_i[7:0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) begin
        if (cmd_i == CMD_LOAD) begin
          w = (img_w < 1) ? 1 : (img_w > 256) ? 256 : img_w;
          h = (img_h < 1) ? 1 : (img_h > 256) ? 256 : img_h;
          if (pixel_x_i < w && pixel_y_i < h) class_img[{pixel_y_i, pixel_x_i}] = pixel_value_i;
        end else begin
          expected_sieve.push_back(predict_sieve(pixel_x_i, pixel_y_i));
        end
      end
      if (out_valid_i && !out_stall_i) begin
        if (expected_sieve.size() == 0) begin
          $display("%0t: unexpected result value %0h replaced %0b", $time,
                   sieved_value_i, was_replaced_i);
          fail_count_o <= fail_count_o + 1;
        end else begin
          exp_r = expected_sieve.pop_front();
          if (exp_r.value !== sieved_value_i || exp_r.replaced !== was_replaced_i) begin
            $display("%0t: mismatch expected value %0h replaced %0b, actual value %0h replaced %0b",
                     $time, exp_r.value, exp_r.replaced, sieved_value_i, was_replaced_i);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
    end
  end

endmodule

// ===== tb/sv/small_particle_sieve_top_test.sv =====
// Testbench top for the small particle sieve: clock, reset, stimulus and the
// verdict. Depends on sps_pkg, small_particle_sieve_top and sieve_checker.
`timescale 1ns / 100ps
module small_particle_sieve_top_test;
  import sps_pkg::*;

  localparam int unsigned IdleLimit = 50000;
  // side of the loaded corner block; queries on large images keep a margin
  localparam int FillSide = 24;
  localparam int SafeSide = FillSide - 5;

  logic       clk, rst_n;
  logic       in_valid, in_stall, cmd;
  logic [7:0] pix_x, pix_y, pix_v;
  logic       out_valid, out_stall, replaced;
  logic [7:0] sieved;
  logic       cfg_valid, cfg_ready;
  logic [2:0] cfg_index;
  logic [8:0] cfg_data;
  int         fail_count, pending;
  bit         idle_on;
  int         stall_left, quiet_cycles;
  int         cur_w, cur_h;
  int         q_w, q_h;

  small_particle_sieve_top u_dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall), .cmd_i(cmd),
    .pixel_x_i(pix_x), .pixel_y_i(pix_y), .pixel_value_i(pix_v),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .sieved_value_o(sieved), .was_replaced_o(replaced),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data)
  );

  sieve_checker u_checker (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_i(in_stall), .cmd_i(cmd),
    .pixel_x_i(pix_x), .pixel_y_i(pix_y), .pixel_value_i(pix_v),
    .out_valid_i(out_valid), .out_stall_i(out_stall),
    .sieved_value_i(sieved), .was_replaced_i(replaced),
    .cfg_valid_i(cfg_valid), .cfg_ready_i(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // result side stalls in bursts
  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      out_stall <= 1'b1;
      stall_left <= $urandom_range(0, 8);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= IdleLimit) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // one input transfer, with an optional gap before it
  task automatic send_item(input logic c, input logic [7:0] x, input logic [7:0] y,
                           input logic [7:0] v);
    bit st;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_valid <= 1'b1;
    cmd <= c; pix_x <= x; pix_y <= y; pix_v <= v;
    forever begin
      @(negedge clk);
      st = in_stall;
      @(posedge clk);
      if (!st) break;
    end
  endtask

  // hold off until every result is in, then let the block settle
  task automatic drain();
    in_valid <= 1'b0;
    forever begin
      @(negedge clk);
      if (pending == 0) break;
    end
    repeat (200) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [8:0] d);
    bit rd;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    forever begin
      @(negedge clk);
      rd = cfg_ready;
      @(posedge clk);
      if (rd) break;
    end
    cfg_valid <= 1'b0;
  endtask

  // query area: on a large image only near the loaded corner block
  task automatic set_phase(input logic [8:0] w, input logic [8:0] h, input logic [8:0] lim,
                           input logic [8:0] lc, input logic [8:0] cc, input logic [8:0] sc);
    drain();
    write_reg(REG_WIDTH, w);
    write_reg(REG_HEIGHT, h);
    write_reg(REG_LIMIT, lim);
    write_reg(REG_LAND, lc);
    write_reg(REG_CLOUD, cc);
    write_reg(REG_SNOW, sc);
    cur_w = (w < 1) ? 1 : (w > 256) ? 256 : w;
    cur_h = (h < 1) ? 1 : (h > 256) ? 256 : h;
    q_w = (cur_w > FillSide && cur_h > 1) ? SafeSide : cur_w;
    q_h = (cur_h > FillSide && cur_w > 1) ? SafeSide : cur_h;
  endtask

  // class codes are drawn mostly from a few values so that particles form
  function automatic logic [7:0] pick_code();
    int r;
    r = $urandom_range(0, 9);
    if (r < 8) return 8'($urandom_range(0, 3));
    return 8'($urandom_range(0, 255));
  endfunction

  // queries mostly inside the query area, some outside the image, some reloads
  task automatic random_items(input int n);
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 19);
      if (r >= 14 && r < 16 && cur_w < 256)
        send_item(CMD_QUERY, 8'($urandom_range(cur_w, 255)), 8'($urandom_range(0, 255)),
                  8'($urandom_range(0, 255)));
      else if (r >= 14 && r < 16 && cur_h < 256)
        send_item(CMD_QUERY, 8'($urandom_range(0, 255)), 8'($urandom_range(cur_h, 255)),
                  8'($urandom_range(0, 255)));
      else if (r < 16)
        send_item(CMD_QUERY, 8'($urandom_range(0, q_w - 1)), 8'($urandom_range(0, q_h - 1)),
                  8'($urandom_range(0, 255)));
      else
        send_item(CMD_LOAD, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                  pick_code());
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0; cmd = CMD_LOAD; pix_x = '0; pix_y = '0; pix_v = '0;
    out_stall = 1'b0;
    cfg_valid = 1'b0; cfg_index = REG_WIDTH; cfg_data = '0;
    idle_on = 1'b1;
    stall_left = 0; quiet_cycles = 0;
    cur_w = 256; cur_h = 256;
    q_w = SafeSide; q_h = SafeSide;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // load the corner block, the top line and the left column; every pixel
    // that a query can reach lies in one of them
    for (int y = 0; y < FillSide; y++)
      for (int x = 0; x < FillSide; x++)
        send_item(CMD_LOAD, 8'(x), 8'(y), pick_code());
    for (int x = FillSide; x < 256; x++)
      send_item(CMD_LOAD, 8'(x), 8'd0, pick_code());
    for (int y = FillSide; y < 256; y++)
      send_item(CMD_LOAD, 8'd0, 8'(y), pick_code());

    // directed: corner, a foreign code, an isolated pixel
    send_item(CMD_QUERY, 8'd0, 8'd0, 8'd0);
    send_item(CMD_LOAD, 8'd10, 8'd10, 8'd255);
    send_item(CMD_QUERY, 8'd10, 8'd10, 8'd0);
    for (int oy = -1; oy <= 1; oy++)
      for (int ox = -1; ox <= 1; ox++)
        send_item(CMD_LOAD, 8'(12 + ox), 8'(12 + oy), (ox == 0 && oy == 0) ? 8'd2 : 8'd0);
    send_item(CMD_QUERY, 8'd12, 8'd12, 8'd0);
    random_items(110);

    // limit zero on a small image; isolated pixel and out-of-range queries
    set_phase(9'd16, 9'd16, 9'd0, 9'd0, 9'd1, 9'd2);
    send_item(CMD_QUERY, 8'd20, 8'd20, 8'd0);
    send_item(CMD_QUERY, 8'd16, 8'd3, 8'd0);
    send_item(CMD_QUERY, 8'd3, 8'd16, 8'd0);
    send_item(CMD_QUERY, 8'd15, 8'd15, 8'd0);
    send_item(CMD_LOAD, 8'd200, 8'd200, 8'd1);
    random_items(110);

    set_phase(9'd1, 9'd256, 9'd16, 9'd0, 9'd1, 9'd2);
    send_item(CMD_QUERY, 8'd0, 8'd255, 8'd0);
    random_items(100);

    set_phase(9'd256, 9'd1, 9'd9, 9'd1, 9'd2, 9'd0);
    send_item(CMD_QUERY, 8'd255, 8'd0, 8'd0);
    random_items(100);

    // out-of-range register values clamp
    set_phase(9'd0, 9'd511, 9'd31, 9'd2, 9'd0, 9'd1);
    random_items(100);

    // shared class codes
    set_phase(9'd7, 9'd5, 9'd8, 9'd3, 9'd3, 9'd2);
    random_items(100);

    set_phase(9'd256, 9'd256, 9'd3, 9'd255, 9'd0, 9'd1);
    random_items(100);

    // closing stretch without idling
    set_phase(9'd256, 9'd256, 9'd5, 9'd0, 9'd1, 9'd2);
    idle_on = 1'b0;
    random_items(120);

    drain();
    if (fail_count == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// ===== files.f =====
hdl/sps_pkg.sv
hdl/sps_ram.sv
hdl/small_particle_sieve_top.sv
hdl/sps_checker.sv
tb/sv/sieve_checker.sv
tb/sv/small_particle_sieve_top_test.sv
